/* design/sspt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspt_pkg
// Shared types and constants for the sorted sector patch table.
// ----------------------------------------------------------------------------
package sspt_pkg;

  // Field widths of one transaction
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 19;
  localparam int HEAD_W = 64;
  localparam int TAIL_W = 32;

  // Input tdata layout, lowest field first, padded to whole bytes
  localparam int IN_BITS = CMD_W + KEY_W + HEAD_W + TAIL_W;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int KEY_LSB  = CMD_W;
  localparam int HEAD_LSB = KEY_LSB + KEY_W;
  localparam int TAIL_LSB = HEAD_LSB + HEAD_W;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Control states of the top level
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Token that walks down the cell chain, one cell per cycle
  typedef struct packed {
    logic              active;    // token present in this slot
    logic              is_insert; // insert (else lookup)
    logic              full;      // table was full when the command started
    logic              done;      // command already resolved upstream
    logic              carrying;  // insert is shifting a displaced entry up
    logic              hit;       // address matched an entry
    logic [KEY_W-1:0]  key;       // search key, or key of the carried entry
    logic [HEAD_W-1:0] head;      // record head (new, carried or found)
    logic [TAIL_W-1:0] tail;      // record tail (new, carried or found)
  } token_t;

endpackage

/* design/sorted_sector_patch_table.sv */
`timescale 1ns / 1ps
// Result path: insert and lookup pass the injection register, every cell and
//   the output register; clear and the unused code pass that register alone.
// Issue: a new insert or lookup is taken only once the last token has left the
//   chain of MAX_ENTRIES cells, which it walks at one cell per cycle.
// Reset: synchronous; the entry count goes to zero and the table reads empty
//   at once (no clearing pass).
// ----------------------------------------------------------------------------
// sorted_sector_patch_table
// Sorted sector address table with 12-byte record per entry, built as a
// chain of cells that a command token walks through.
// ----------------------------------------------------------------------------
module sorted_sector_patch_table #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // command, sector_addr, record_head, record_tail (zero padded)
  input  logic [sspt_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // hit, table_full, found_head, found_tail, entry_total (zero padded)
  output logic [((2 + sspt_pkg::HEAD_W + sspt_pkg::TAIL_W + $clog2(MAX_ENTRIES + 1)
                  + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int OUT_BITS = 2 + sspt_pkg::HEAD_W + sspt_pkg::TAIL_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CNT_W-1:0]            total;
    logic [sspt_pkg::TAIL_W-1:0] tail;
    logic [sspt_pkg::HEAD_W-1:0] head;
    logic                        full;
    logic                        hit;
  } result_t;

  sspt_pkg::state_t state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  sspt_pkg::token_t inj;
  sspt_pkg::token_t chain [MAX_ENTRIES+1];
  sspt_pkg::token_t ext;
  sspt_pkg::cmd_t   cmd;

  logic    acc;
  logic    launch;
  logic    tbl_full;
  logic    res_ev;
  result_t res;
  logic    out_valid, hold_valid;
  result_t out_data, hold_data;
  logic    out_load;

  assign cmd      = sspt_pkg::cmd_t'(s_tdata[sspt_pkg::CMD_W-1:0]);
  assign acc      = s_tvalid && s_tready;
  assign tbl_full = (fill == CNT_W'(MAX_ENTRIES));
  assign ext      = chain[MAX_ENTRIES];

  // Command decode: insert and lookup go down the chain
  always_comb begin
    unique case (cmd) inside
      sspt_pkg::CMD_INSERT,
      sspt_pkg::CMD_LOOKUP: launch = 1'b1;
      default:              launch = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sspt_pkg::ST_IDLE: begin
        if (acc && launch) state_next = sspt_pkg::ST_RUN;
      end
      sspt_pkg::ST_RUN: begin
        if (ext.active) state_next = sspt_pkg::ST_IDLE;
      end
      default: state_next = sspt_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready = 1'b0;
    unique case (state)
      sspt_pkg::ST_IDLE: s_tready = !hold_valid;
      sspt_pkg::ST_RUN:  s_tready = 1'b0;
      default:           s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sspt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Entry count update: grows when an insert placed a new entry, zero on clear
  always_comb begin
    fill_next = fill;
    if (ext.active && ext.is_insert && !ext.hit && !ext.full) begin
      fill_next = fill + CNT_W'(1);
    end else if (acc && cmd == sspt_pkg::CMD_CLEAR) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Token injection into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      inj <= '0;
    end else begin
      inj.active    <= acc && launch;
      inj.is_insert <= (cmd == sspt_pkg::CMD_INSERT);
      inj.full      <= tbl_full;
      inj.done      <= 1'b0;
      inj.carrying  <= 1'b0;
      inj.hit       <= 1'b0;
      inj.key       <= s_tdata[sspt_pkg::KEY_LSB +: sspt_pkg::KEY_W];
      inj.head      <= s_tdata[sspt_pkg::HEAD_LSB +: sspt_pkg::HEAD_W];
      inj.tail      <= s_tdata[sspt_pkg::TAIL_LSB +: sspt_pkg::TAIL_W];
    end
  end

  assign chain[0] = inj;

  // Cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    sspt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .fill    (fill),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Result assembly: from the chain exit, or at once for clear / no-op
  always_comb begin
    res_ev = 1'b0;
    res    = '0;
    if (ext.active) begin
      res_ev   = 1'b1;
      res.hit  = ext.hit;
      res.full = ext.is_insert && !ext.hit && ext.full;
      if (!ext.is_insert && ext.hit) begin
        res.head = ext.head;
        res.tail = ext.tail;
      end
      res.total = fill_next;
    end else if (acc && !launch) begin
      res_ev    = 1'b1;
      res.total = fill_next;
    end
  end

  // Output register plus one hold slot
  assign out_load = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= hold_valid || res_ev;
      hold_valid <= hold_valid && res_ev;
    end else if (res_ev) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= hold_valid ? hold_data : res;
      if (res_ev) hold_data <= res;
    end else if (res_ev) begin
      hold_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);

endmodule

/* design/sspt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspt_cell
// One table slot: holds an entry and processes the passing token.
// A cell holds a live entry when its index is below the fill count.
// ----------------------------------------------------------------------------
module sspt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CNT_W-1:0]   fill,
  input  sspt_pkg::token_t   tok_in,
  output sspt_pkg::token_t   tok_out
);

  logic [sspt_pkg::KEY_W-1:0]  key;
  logic [sspt_pkg::HEAD_W-1:0] head;
  logic [sspt_pkg::TAIL_W-1:0] tail;

  sspt_pkg::token_t tok_next;
  logic             live;
  logic             wr;

  assign live = (fill > CNT_W'(IDX));

  // Token processing: match, pass, place, or swap with the carried entry
  always_comb begin
    tok_next = tok_in;
    wr       = 1'b0;
    if (tok_in.active && !tok_in.done) begin
      if (tok_in.carrying) begin
        wr = 1'b1;
        if (live) begin
          tok_next.key  = key;
          tok_next.head = head;
          tok_next.tail = tail;
        end else begin
          tok_next.done     = 1'b1;
          tok_next.carrying = 1'b0;
        end
      end else if (live && key == tok_in.key) begin
        tok_next.hit  = 1'b1;
        tok_next.done = 1'b1;
        if (tok_in.is_insert) begin
          wr = 1'b1;
        end else begin
          tok_next.head = head;
          tok_next.tail = tail;
        end
      end else if (live && key < tok_in.key) begin
        tok_next = tok_in;
      end else if (!tok_in.is_insert || tok_in.full) begin
        // address absent: lookup misses, insert into a full table drops
        tok_next.done = 1'b1;
      end else begin
        // sorted position found: place here, shift the old entry up
        wr = 1'b1;
        if (live) begin
          tok_next.carrying = 1'b1;
          tok_next.key      = key;
          tok_next.head     = head;
          tok_next.tail     = tail;
        end else begin
          tok_next.done = 1'b1;
        end
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      key  <= tok_in.key;
      head <= tok_in.head;
      tail <= tok_in.tail;
    end
  end

  // Token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted sector patch table. Drives insert,
// lookup, clear and the unused command code over the input stream. A shadow
// copy of the sorted table predicts every reply, and each reply on the output
// stream is checked field by field. Covers empty and full tables, overwrite
// on a full table, long output back-pressure, and random traffic under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

  // Field widths and input layout
  localparam int CMD_W    = sspt_pkg::CMD_W;
  localparam int KEY_W    = sspt_pkg::KEY_W;
  localparam int HEAD_W   = sspt_pkg::HEAD_W;
  localparam int TAIL_W   = sspt_pkg::TAIL_W;
  localparam int IN_W     = sspt_pkg::IN_W;
  localparam int KEY_LSB  = sspt_pkg::KEY_LSB;
  localparam int HEAD_LSB = sspt_pkg::HEAD_LSB;
  localparam int TAIL_LSB = sspt_pkg::TAIL_LSB;

  localparam int DEPTH       = 256;
  localparam int TOTAL_W     = 9;
  localparam int OUT_W       = 112;
  localparam int LATENCY     = DEPTH + 2;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  // Output tdata layout, lowest field first
  localparam int HIT_BIT   = 0;
  localparam int FULL_BIT  = 1;
  localparam int FHEAD_LSB = 2;
  localparam int FTAIL_LSB = FHEAD_LSB + HEAD_W;
  localparam int TOTAL_LSB = FTAIL_LSB + TAIL_W;

  // Code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  typedef struct {
    logic               hit;
    logic               full;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
    logic [TOTAL_W-1:0] total;
  } patch_reply_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  sorted_sector_patch_table #(
    .MAX_ENTRIES(DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Shadow copy of the sorted table
  logic [KEY_W-1:0]  shadow_keys  [DEPTH];
  logic [HEAD_W-1:0] shadow_heads [DEPTH];
  logic [TAIL_W-1:0] shadow_tails [DEPTH];
  int                shadow_count = 0;

  patch_reply_t pending_replies [$];
  int           error_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_request   = 0;
  int           hold_left      = 0;

  initial forever #5 clk = ~clk;

  // Apply one command to the shadow table and return the reply it gives
  function automatic patch_reply_t table_apply(input logic [CMD_W-1:0] op,
                                               input logic [KEY_W-1:0] addr,
                                               input logic [HEAD_W-1:0] head,
                                               input logic [TAIL_W-1:0] tail);
    patch_reply_t r;
    int           pos;
    bit           match;
    r = '{default: '0};
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < addr) pos++;
    match = (pos < shadow_count) && (shadow_keys[pos] == addr);
    case (op)
      sspt_pkg::CMD_INSERT: begin
        if (match) begin
          shadow_heads[pos] = head;
          shadow_tails[pos] = tail;
          r.hit = 1'b1;
        end else if (shadow_count >= DEPTH) begin
          r.full = 1'b1;
        end else begin
          // open a slot at the sorted position
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i]  = shadow_keys[i-1];
            shadow_heads[i] = shadow_heads[i-1];
            shadow_tails[i] = shadow_tails[i-1];
          end
          shadow_keys[pos]  = addr;
          shadow_heads[pos] = head;
          shadow_tails[pos] = tail;
          shadow_count++;
        end
      end
      sspt_pkg::CMD_LOOKUP: begin
        if (match) begin
          r.hit  = 1'b1;
          r.head = shadow_heads[pos];
          r.tail = shadow_tails[pos];
        end
      end
      sspt_pkg::CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.total = shadow_count[TOTAL_W-1:0];
    return r;
  endfunction

  // Send one command; the reply is predicted once the transaction is accepted
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] addr,
                           input logic [HEAD_W-1:0] head, input logic [TAIL_W-1:0] tail);
    logic [IN_W-1:0] word;
    word = '0;
    word[0 +: CMD_W]        = op;
    word[KEY_LSB +: KEY_W]   = addr;
    word[HEAD_LSB +: HEAD_W] = head;
    word[TAIL_LSB +: TAIL_W] = tail;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_replies.push_back(table_apply(op, addr, head, tail));
  endtask

  // Drop valid and wait until every predicted reply has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [HEAD_W-1:0] want,
                              input logic [HEAD_W-1:0] seen);
    error_count++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
  endtask

  // Output side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Reply checker
  always @(posedge clk) begin
    patch_reply_t want, seen;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      seen.hit   = m_tdata[HIT_BIT];
      seen.full  = m_tdata[FULL_BIT];
      seen.head  = m_tdata[FHEAD_LSB +: HEAD_W];
      seen.tail  = m_tdata[FTAIL_LSB +: TAIL_W];
      seen.total = m_tdata[TOTAL_LSB +: TOTAL_W];
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("%0t: reply with none expected, actual %h", $time, m_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (seen.hit !== want.hit)
          report_field("hit", HEAD_W'(want.hit), HEAD_W'(seen.hit));
        if (seen.full !== want.full)
          report_field("table_full", HEAD_W'(want.full), HEAD_W'(seen.full));
        if (seen.head !== want.head)
          report_field("found_head", want.head, seen.head);
        if (seen.tail !== want.tail)
          report_field("found_tail", HEAD_W'(want.tail), HEAD_W'(seen.tail));
        if (seen.total !== want.total)
          report_field("entry_total", HEAD_W'(want.total), HEAD_W'(seen.total));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Empty table, edge addresses, every command and the corner cases
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(sspt_pkg::CMD_LOOKUP, '0, '1, '1);               // lookup on empty table
    send_item(sspt_pkg::CMD_INSERT, 19'd1000, 64'h0123456789ABCDEF, 32'h89ABCDEF);
    send_item(sspt_pkg::CMD_INSERT, KEY_MAX, '1, '1);          // goes to the end
    send_item(sspt_pkg::CMD_INSERT, '0, '0, '0);               // goes to the front
    send_item(sspt_pkg::CMD_INSERT, 19'd500, 64'hAAAAAAAAAAAAAAAA, 32'h55555555);
    send_item(sspt_pkg::CMD_LOOKUP, '0, '1, '1);
    send_item(sspt_pkg::CMD_LOOKUP, KEY_MAX, '0, '0);
    send_item(sspt_pkg::CMD_LOOKUP, 19'd500, '0, '0);
    send_item(sspt_pkg::CMD_LOOKUP, 19'd501, '0, '0);          // miss between entries
    send_item(sspt_pkg::CMD_INSERT, 19'd1000, 64'h5555555555555555,
              32'hAAAAAAAA);                                   // overwrite
    send_item(sspt_pkg::CMD_LOOKUP, 19'd1000, '0, '0);
    send_item(CMD_UNUSED, 19'd500, '1, '1);                    // no operation
    send_item(sspt_pkg::CMD_LOOKUP, 19'd499, '0, '0);
    send_item(sspt_pkg::CMD_LOOKUP, KEY_MAX - 19'd1, '0, '0);
    send_item(sspt_pkg::CMD_CLEAR, KEY_MAX, '1, '1);
    send_item(sspt_pkg::CMD_LOOKUP, 19'd1000, '0, '0);         // miss after clear
    send_item(CMD_UNUSED, '0, '0, '0);                         // no operation, empty
    send_item(sspt_pkg::CMD_CLEAR, '0, '0, '0);                // clear when empty
    send_item(sspt_pkg::CMD_INSERT, 19'd7, 64'hFEDCBA9876543210, 32'h01234567);
    send_item(sspt_pkg::CMD_LOOKUP, 19'd7, '1, '1);
    wait_drain();
  endtask

  // Fill to capacity, then new and existing addresses on the full table
  task automatic test_full_table();
    logic [KEY_W-1:0] fresh;
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    send_item(sspt_pkg::CMD_CLEAR, '0, '0, '0);
    send_item(sspt_pkg::CMD_INSERT, '0, {$urandom, $urandom}, $urandom);
    send_item(sspt_pkg::CMD_INSERT, KEY_MAX, {$urandom, $urandom}, $urandom);
    while (shadow_count < DEPTH)
      send_item(sspt_pkg::CMD_INSERT, KEY_W'($urandom), {$urandom, $urandom}, $urandom);
    // find an address not held in the table
    fresh = shadow_keys[0] + 19'd1;
    for (int i = 0; i + 1 < DEPTH; i++) begin
      if (shadow_keys[i+1] - shadow_keys[i] > 1) fresh = shadow_keys[i] + 19'd1;
    end
    send_item(sspt_pkg::CMD_INSERT, fresh, '1, '1);            // dropped, table full
    send_item(sspt_pkg::CMD_LOOKUP, fresh, '0, '0);
    send_item(sspt_pkg::CMD_INSERT, shadow_keys[DEPTH/2], '0, '1); // overwrite while full
    send_item(sspt_pkg::CMD_LOOKUP, shadow_keys[DEPTH/2], '0, '0);
    send_item(sspt_pkg::CMD_INSERT, KEY_MAX, '1, '0);
    send_item(sspt_pkg::CMD_LOOKUP, KEY_MAX, '0, '0);
    send_item(sspt_pkg::CMD_LOOKUP, '0, '0, '0);
    send_item(CMD_UNUSED, fresh, '1, '1);
    send_item(sspt_pkg::CMD_CLEAR, '0, '0, '0);
    wait_drain();
  endtask

  // Output held off for a long stretch while commands keep coming
  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    repeat (4) send_item(sspt_pkg::CMD_INSERT, KEY_W'($urandom_range(31)),
                         {$urandom, $urandom}, $urandom);
    repeat (4) send_item(sspt_pkg::CMD_LOOKUP, KEY_W'($urandom_range(31)),
                         {$urandom, $urandom}, $urandom);
    // sender stops until every reply is back
    wait_drain();
    repeat (3) send_item(sspt_pkg::CMD_LOOKUP, KEY_W'($urandom_range(31)), '0, '0);
    wait_drain();
  endtask

  // Random commands, biased toward addresses already held or next to them
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int               pick;
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] addr;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 47)      op = sspt_pkg::CMD_INSERT;
      else if (pick < 95) op = sspt_pkg::CMD_LOOKUP;
      else if (pick < 96) op = sspt_pkg::CMD_CLEAR;
      else                op = CMD_UNUSED;
      pick = $urandom_range(99);
      if (shadow_count > 0 && pick < 45)
        addr = shadow_keys[$urandom_range(shadow_count - 1)];
      else if (shadow_count > 0 && pick < 60)
        addr = shadow_keys[$urandom_range(shadow_count - 1)] + ($urandom_range(1) ? 19'd1 : '1);
      else if (pick < 70)
        addr = $urandom_range(1) ? KEY_W'($urandom_range(3)) : KEY_MAX - KEY_W'($urandom_range(3));
      else
        addr = KEY_W'($urandom);
      send_item(op, addr, {$urandom, $urandom}, $urandom);
    end
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_back_pressure();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 65, 0);
    test_random_traffic(240, 0, 65);
    test_random_traffic(240, 16, 16);
    wait_drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (pending_replies.size() != 0) begin
      error_count++;
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sspt_pkg.sv
design/sspt_cell.sv
design/sorted_sector_patch_table.sv
tb/tb.sv
